FILE: hdl/dwpt_pkg.sv
// Shared types and constants of the dual wheel period tachometer.
`default_nettype none
package dwpt_pkg;

  // Field widths
  localparam int unsigned STAMP_BITS = 16;
  localparam int unsigned PERIOD_W   = STAMP_BITS + 1;
  localparam int unsigned SPEED_W    = 22;
  localparam int unsigned PULSE_W    = 32;
  localparam int unsigned STALL_W    = 2;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register reset values
  localparam logic [SPEED_W-1:0] SPEED_CONST_RST = SPEED_W'(1684949);
  localparam logic [STALL_W-1:0] STALL_LIMIT_RST = STALL_W'(2);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CONST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 1'b1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CAPTURE  = 2'd0,
    CMD_OVERFLOW = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic                  wheel_select;
    logic [STAMP_BITS-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0]  left_speed;
    logic [SPEED_W-1:0]  right_speed;
    logic [PERIOD_W-1:0] left_period;
    logic [PERIOD_W-1:0] right_period;
    logic [PULSE_W-1:0]  left_pulses;
    logic [PULSE_W-1:0]  right_pulses;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hdl/dwpt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module dwpt_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dwpt_pkg::SPEED_W-1:0]   dividend_i,
  input  logic [dwpt_pkg::PERIOD_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [dwpt_pkg::SPEED_W-1:0]   quotient_o
);
  import dwpt_pkg::*;

  localparam int unsigned CNT_W = $clog2(SPEED_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPEED_W - 1);

  logic [SPEED_W-1:0]  num_q, num_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [PERIOD_W-1:0] dvs_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;
  logic [PERIOD_W:0]   rem_shift, trial;
  logic                qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem_q, num_q[SPEED_W-1]};
    trial     = rem_shift - {1'b0, dvs_q};
    qbit      = (rem_shift >= {1'b0, dvs_q});
    rem_d     = qbit ? trial[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
    num_d     = {num_q[SPEED_W-2:0], qbit};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule
`default_nettype wire

FILE: hdl/dual_wheel_period_tachometer.sv
// Top level of the dual wheel period tachometer.
`default_nettype none
// Two-wheel encoder tachometer. Each transaction is a capture edge, a timer
// overflow tick or an odometer clear, and returns one result with both wheels'
// speed, period and pulse count as they stand after it. For overflow ticks,
// clears and unused commands the result goes straight to the output state.
// A capture first waits in the division state for the bit-serial divider
// that forms the speed one quotient bit per cycle (22 bits). The input is
// freed once the result is loaded into the output register; that load waits
// while an offered result is not yet taken. One transaction is processed at
// a time; the next one is accepted while the previous result still waits in
// the output register. A zero period counts as a full 65536-tick wrap, and a
// wheel whose stall count reaches the stall limit reads speed zero until the
// division of its next capture lands.
module dual_wheel_period_tachometer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dwpt_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dwpt_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [dwpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dwpt_pkg::SPEED_W-1:0]    cfg_wdata_i
);
  import dwpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]            state_q;
  logic [SPEED_W-1:0]    speed_const_q;
  logic [STALL_W-1:0]    stall_limit_q;
  logic [STAMP_BITS-1:0] last_stamp_q [2];
  logic [PERIOD_W-1:0]   period_q     [2];
  logic [SPEED_W-1:0]    speed_q      [2];
  logic [PULSE_W-1:0]    pulses_q     [2];
  logic [STALL_W-1:0]    stall_q      [2];
  logic                  wheel_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  logic                  in_fire;
  logic                  wsel;
  logic [STAMP_BITS-1:0] diff;
  logic [PERIOD_W-1:0]   period_new;
  logic                  div_start, div_done;
  logic [SPEED_W-1:0]    quotient;
  logic                  out_load;
  logic [STALL_W:0]      stall_nxt [2];
  logic                  stall_hit [2];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wsel       = in_item_i.wheel_select;
  assign div_start  = in_fire && (in_item_i.command == CMD_CAPTURE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Period since the wheel's last stamp, zero taken as a full wrap
  always_comb begin
    diff       = in_item_i.stamp - last_stamp_q[wsel];
    period_new = (diff == '0) ? (PERIOD_W'(1) << STAMP_BITS) : {1'b0, diff};
  end

  // Stall count step per wheel
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      stall_nxt[w] = {1'b0, stall_q[w]} + (STALL_W+1)'(1);
      stall_hit[w] = (stall_nxt[w] >= {1'b0, stall_limit_q});
    end
  end

  dwpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (speed_const_q),
    .divisor_i  (period_new),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_const_q <= SPEED_CONST_RST;
      stall_limit_q <= STALL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SPEED_CONST: speed_const_q <= cfg_wdata_i;
        CFG_STALL_LIMIT: stall_limit_q <= cfg_wdata_i[STALL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= (in_item_i.command == CMD_CAPTURE) ? ST_DIV : ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Wheel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= 1'b0;
      for (int w = 0; w < 2; w++) begin
        last_stamp_q[w] <= '0;
        period_q[w]     <= '0;
        speed_q[w]      <= '0;
        pulses_q[w]     <= '0;
        stall_q[w]      <= '0;
      end
    end else begin
      if (in_fire) begin
        case (in_item_i.command)
          CMD_CAPTURE: begin
            wheel_q            <= wsel;
            last_stamp_q[wsel] <= in_item_i.stamp;
            period_q[wsel]     <= period_new;
            pulses_q[wsel]     <= pulses_q[wsel] + PULSE_W'(1);
            stall_q[wsel]      <= '0;
          end
          CMD_OVERFLOW: begin
            for (int w = 0; w < 2; w++) begin
              if (stall_hit[w]) begin
                speed_q[w] <= '0;
                stall_q[w] <= stall_limit_q;
              end else begin
                stall_q[w] <= stall_nxt[w][STALL_W-1:0];
              end
            end
          end
          CMD_CLEAR: pulses_q[wsel] <= '0;
          default: ;
        endcase
      end
      // Speed lands once the divider finishes
      if (div_done) begin
        speed_q[wheel_q] <= quotient;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.left_speed   <= speed_q[0];
      out_item_q.right_speed  <= speed_q[1];
      out_item_q.left_period  <= period_q[0];
      out_item_q.right_period <= period_q[1];
      out_item_q.left_pulses  <= pulses_q[0];
      out_item_q.right_pulses <= pulses_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // A capture always hands over to the divider
  a_capture_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == ST_DIV)
    else $error("capture did not start the division");

  // The divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the division state");

  // A new result appears only when leaving the output state
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT && state_q == ST_IDLE)
    else $error("result raised outside the output state");
`endif

endmodule
`default_nettype wire
